>>> rtl/dcr_pkg.sv
`timescale 1ns / 1ps
package dcr_pkg;

    localparam int IN_TDATA_W  = 296;
    localparam int OUT_TDATA_W = 200;
    localparam int COORD_W     = 32;
    localparam int MASS_W      = 32;
    localparam int REST_W      = 31;
    localparam int STIFF_W     = 17;
    localparam logic [STIFF_W-1:0] STIFF_RESET = 17'h10000;

    // squared separation and its root
    localparam int SUM_W    = 66;
    localparam int SQ_RAD_W = 68;
    localparam int LEN_W    = 34;
    localparam int SQ_STEPS = 34;
    localparam int SQ_REM_W = 37;

    localparam int DIV_DW      = 34;
    localparam int TAIL_STAGES = 13;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][COORD_W-1:0] p2;
        logic                    mov1;
        logic                    mov2;
        logic                    degen;
    } t_link;

    typedef struct packed {
        t_link              lk;
        logic [REST_W-1:0]  rest;
        logic [MASS_W:0]    tot;
        logic [MASS_W-1:0]  m2;
    } t_sqside;

    typedef struct packed {
        t_link lk;
        logic  neg;
        logic  totz;
    } t_dvside;

endpackage

>>> rtl/dcr_sqrt.sv
`timescale 1ns / 1ps
module dcr_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [dcr_pkg::SUM_W-1:0]   i_rad,
    output logic [dcr_pkg::LEN_W-1:0]   o_root
);
    import dcr_pkg::*;

    logic [SQ_REM_W-1:0] r_rem  [SQ_STEPS];
    logic [LEN_W-1:0]    r_root [SQ_STEPS];
    logic [SQ_RAD_W-1:0] r_rad  [SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
        logic [SQ_REM_W-1:0] rem_in;
        logic [LEN_W-1:0]    root_in;
        logic [SQ_RAD_W-1:0] rad_in;
        logic [SQ_REM_W-1:0] sh;
        logic [SQ_REM_W-1:0] trial;
        logic                ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = {{(SQ_RAD_W-SUM_W){1'b0}}, i_rad};
        end else begin : g_next
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign rad_in  = r_rad[i-1];
        end

        assign sh    = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
        assign trial = {{(SQ_REM_W-LEN_W-2){1'b0}}, root_in, 2'b01};
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= ge ? (sh - trial) : sh;
                r_root[i] <= {root_in[LEN_W-2:0], ge};
                r_rad[i]  <= {rad_in[SQ_RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

>>> rtl/dcr_div.sv
`timescale 1ns / 1ps
module dcr_div #(
    parameter int NW = 49,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar i = 0; i < NW; i++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign num_in = r_num[i-1];
            assign quo_in = r_quo[i-1];
            assign den_in = r_den[i-1];
        end

        assign sh   = {rem_in, num_in[NW-1]};
        assign ge   = (sh >= {1'b0, den_in});
        assign diff = sh - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= ge ? diff[DW-1:0] : sh[DW-1:0];
                r_num[i] <= {num_in[NW-2:0], 1'b0};
                r_quo[i] <= {quo_in[NW-2:0], ge};
                r_den[i] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

>>> rtl/distance_constraint_resolver.sv
`timescale 1ns / 1ps
// distance constraint resolver for cloth links
// s_axis: one link request per beat, tdata from bit 0 up: first_x, first_y,
//   first_z, second_x, second_y, second_z, first_mass, second_mass,
//   first_movable, second_movable, rest_length, zero fill
// m_axis: one result per link, tdata from bit 0 up: new_first_x/y/z,
//   new_second_x/y/z, degenerate, zero fill
// i_cfg_we / i_cfg_wdata: stiffness write, unsigned Q1.16, write only while idle
// pipeline: an input and squaring front end, a 34-step bit-per-stage square
//   root, a bit-per-stage divider of 33 + COORD_FRAC_BITS steps for the ratio
//   and mass weight, and a 13-stage multiply and saturate tail
// throughput: one link per cycle unless stalled; the whole pipe moves as one unit
// stall: when the output is held and m_axis_tready is low, every stage
//   holds and s_axis_tready drops in the same cycle; nothing is lost
// reset: all valid bits clear, stiffness returns to 1.0
module distance_constraint_resolver #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, first_mass,
    // second_mass, first_movable, second_movable, rest_length
    input  logic [dcr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // new_first_x/y/z, new_second_x/y/z, degenerate
    output logic [dcr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [dcr_pkg::STIFF_W-1:0]         i_cfg_wdata
);
    import dcr_pkg::*;

    localparam int F   = COORD_FRAC_BITS;
    localparam int NW  = 33 + F;
    localparam int WW  = F + 1;
    localparam int LAT = 3 + SQ_STEPS + 1 + NW + TAIL_STAGES;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] res;
        if (v[63:31] == '0 || v[63:31] == '1) begin
            res = v[31:0];
        end else begin
            res = v[63] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return res;
    endfunction

    logic              en;
    logic              r_vld [LAT];
    logic [STIFF_W-1:0] r_stiff;

    assign en            = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= STIFF_RESET;
        end else if (i_cfg_we) begin
            r_stiff <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // front end: separation, squares, sum
    t_link             in_lk;
    t_sqside           n_s1_sd;
    logic [32:0]       n_s1_abs [3];
    t_sqside           r_s1_sd, r_s2_sd, r_s3_sd;
    logic [32:0]       r_s1_abs [3];
    logic [65:0]       r_s2_sq  [3];
    logic [SUM_W-1:0]  r_s3_sum;

    always_comb begin
        logic [32:0] dd;
        in_lk.p1[0] = s_axis_tdata[31:0];
        in_lk.p1[1] = s_axis_tdata[63:32];
        in_lk.p1[2] = s_axis_tdata[95:64];
        in_lk.p2[0] = s_axis_tdata[127:96];
        in_lk.p2[1] = s_axis_tdata[159:128];
        in_lk.p2[2] = s_axis_tdata[191:160];
        in_lk.mov1  = s_axis_tdata[256];
        in_lk.mov2  = s_axis_tdata[257];
        in_lk.degen = (in_lk.p1 == in_lk.p2);
        for (int k = 0; k < 3; k++) begin
            dd = {in_lk.p1[k][31], in_lk.p1[k]} - {in_lk.p2[k][31], in_lk.p2[k]};
            n_s1_abs[k] = dd[32] ? (33'd0 - dd) : dd;
        end
        n_s1_sd.lk   = in_lk;
        n_s1_sd.rest = s_axis_tdata[288:258];
        n_s1_sd.m2   = s_axis_tdata[255:224];
        n_s1_sd.tot  = {1'b0, s_axis_tdata[223:192]} + {1'b0, s_axis_tdata[255:224]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sd <= n_s1_sd;
            r_s2_sd <= r_s1_sd;
            r_s3_sd <= r_s2_sd;
            for (int k = 0; k < 3; k++) begin
                r_s1_abs[k] <= n_s1_abs[k];
                r_s2_sq[k]  <= {33'd0, r_s1_abs[k]} * {33'd0, r_s1_abs[k]};
            end
            r_s3_sum <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
        end
    end

    // square root with its sidecar
    logic [LEN_W-1:0] len;
    t_sqside          r_sqs [SQ_STEPS];

    dcr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_s3_sum),
        .o_root (len)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqs[0] <= r_s3_sd;
            for (int i = 1; i < SQ_STEPS; i++) r_sqs[i] <= r_sqs[i-1];
        end
    end

    // ratio and weight dividends
    t_sqside        sq_out;
    logic [34:0]    sdiff;
    logic [34:0]    smag;
    logic [NW-1:0]  r_s4_numq, r_s4_numw;
    logic [DIV_DW-1:0] r_s4_denq, r_s4_denw;
    t_dvside        r_s4_dv;

    assign sq_out = r_sqs[SQ_STEPS-1];
    assign sdiff  = {1'b0, len} - {4'b0, sq_out.rest};
    assign smag   = sdiff[34] ? (35'd0 - sdiff) : sdiff;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_numq     <= {smag[32:0], {F{1'b0}}};
            r_s4_denq     <= len;
            r_s4_numw     <= {1'b0, sq_out.m2, {F{1'b0}}};
            r_s4_denw     <= {1'b0, sq_out.tot};
            r_s4_dv.lk    <= sq_out.lk;
            r_s4_dv.neg   <= sdiff[34];
            r_s4_dv.totz  <= (sq_out.tot == '0);
        end
    end

    logic [NW-1:0] quo_q, quo_w;
    t_dvside       r_dvs [NW];

    dcr_div #(.NW(NW), .DW(DIV_DW)) u_div_ratio (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s4_numq),
        .i_den (r_s4_denq),
        .o_quo (quo_q)
    );

    dcr_div #(.NW(NW), .DW(DIV_DW)) u_div_weight (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s4_numw),
        .i_den (r_s4_denw),
        .o_quo (quo_w)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvs[0] <= r_s4_dv;
            for (int i = 1; i < NW; i++) r_dvs[i] <= r_dvs[i-1];
        end
    end

    // tail: per-axis correction and split
    t_dvside       dv_out;
    logic [63:0]   q_zext;
    logic [63:0]   r_q;
    logic [WW-1:0] r_w [7];
    t_link         r_tl [TAIL_STAGES];

    assign dv_out = r_dvs[NW-1];
    assign q_zext = {{(64-NW){1'b0}}, quo_q};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q      <= dv_out.neg ? (64'd0 - q_zext) : q_zext;
            r_w[0]   <= dv_out.totz ? {2'b01, {(F-1){1'b0}}} : quo_w[WW-1:0];
            for (int i = 1; i < 7; i++) r_w[i] <= r_w[i-1];
            r_tl[0]  <= dv_out.lk;
            for (int i = 1; i < TAIL_STAGES; i++) r_tl[i] <= r_tl[i-1];
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic [32:0]      r_d;
        logic [63:0]      d64;
        logic [31:0]      mx, my, cs_hi_full, ew_hi_full;
        logic [63:0]      r_p00, r_prod, r_c, r_cp, r_e6, r_ep;
        logic [31:0]      r_pm, r_cs_hi, r_ew_hi;
        logic [48:0]      r_cs_lo;
        logic [32+WW-1:0] r_ew_lo;
        logic [63:0]      r_e7, r_e8, r_e9, r_e10, r_a9, r_a10, r_b10;
        logic [63:0]      r_r1, r_r2;
        logic [31:0]      r_nf, r_ns;
        logic [63:0]      bias_c, bias_e, bias_a;
        logic [63:0]      p1_64, p2_64;
        t_link            lk11;

        assign d64        = {{31{r_d[32]}}, r_d};
        assign mx         = d64[31:0] * r_q[63:32];
        assign my         = d64[63:32] * r_q[31:0];
        assign cs_hi_full = r_c[63:32] * {15'd0, r_stiff};
        assign ew_hi_full = r_e6[63:32] * {{(32-WW){1'b0}}, r_w[6]};
        assign bias_c     = r_prod[63] ? {{(64-F){1'b0}}, {F{1'b1}}} : 64'd0;
        assign bias_e     = r_cp[63] ? 64'h0000_0000_0000_ffff : 64'd0;
        assign bias_a     = r_ep[63] ? {{(64-F){1'b0}}, {F{1'b1}}} : 64'd0;
        assign lk11       = r_tl[10];
        assign p1_64      = {{32{lk11.p1[k][31]}}, lk11.p1[k]};
        assign p2_64      = {{32{lk11.p2[k][31]}}, lk11.p2[k]};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d     <= {dv_out.lk.p1[k][31], dv_out.lk.p1[k]}
                           - {dv_out.lk.p2[k][31], dv_out.lk.p2[k]};
                r_p00   <= {32'd0, d64[31:0]} * {32'd0, r_q[31:0]};
                r_pm    <= mx + my;
                r_prod  <= r_p00 + {r_pm, 32'd0};
                r_c     <= 64'($signed(r_prod + bias_c) >>> F);
                r_cs_lo <= {17'd0, r_c[31:0]} * {32'd0, r_stiff};
                r_cs_hi <= cs_hi_full;
                r_cp    <= {15'd0, r_cs_lo} + {r_cs_hi, 32'd0};
                r_e6    <= 64'($signed(r_cp + bias_e) >>> 16);
                r_ew_lo <= {{WW{1'b0}}, r_e6[31:0]} * {32'd0, r_w[6]};
                r_ew_hi <= ew_hi_full;
                r_e7    <= r_e6;
                r_ep    <= {{(32-WW){1'b0}}, r_ew_lo} + {r_ew_hi, 32'd0};
                r_e8    <= r_e7;
                r_a9    <= 64'($signed(r_ep + bias_a) >>> F);
                r_e9    <= r_e8;
                r_b10   <= r_e9 - r_a9;
                r_a10   <= r_a9;
                r_e10   <= r_e9;
                if (lk11.degen || !lk11.mov1) begin
                    r_r1 <= p1_64;
                end else if (lk11.mov2) begin
                    r_r1 <= p1_64 - r_a10;
                end else begin
                    r_r1 <= p1_64 - r_e10;
                end
                if (lk11.degen || !lk11.mov2) begin
                    r_r2 <= p2_64;
                end else if (lk11.mov1) begin
                    r_r2 <= p2_64 + r_b10;
                end else begin
                    r_r2 <= p2_64 + r_e10;
                end
                r_nf <= sat32(r_r1);
                r_ns <= sat32(r_r2);
            end
        end

        assign m_axis_tdata[32*k +: 32]      = r_nf;
        assign m_axis_tdata[96 + 32*k +: 32] = r_ns;
    end

    assign m_axis_tdata[192] = r_tl[TAIL_STAGES-1].degen;
    assign m_axis_tdata[OUT_TDATA_W-1:193] = '0;

endmodule

>>> rtl/dcr_checker.sv
`timescale 1ns / 1ps
module dcr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dcr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output slot");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind distance_constraint_resolver dcr_checker u_dcr_checker (.*);

>>> bench/distance_constraint_resolver_tb.sv
`timescale 1ns / 1ps
module distance_constraint_resolver_tb;
    import dcr_pkg::*;

    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 130;

    typedef struct {
        logic signed [COORD_W-1:0] p1 [3];
        logic signed [COORD_W-1:0] p2 [3];
        logic [MASS_W-1:0]         m1;
        logic [MASS_W-1:0]         m2;
        logic                      mov1;
        logic                      mov2;
        logic [REST_W-1:0]         rest;
    } t_link_in;

    typedef struct {
        logic signed [COORD_W-1:0] np [6];
        logic                      degen;
    } t_link_out;

    function automatic logic [IN_TDATA_W-1:0] pack_link(t_link_in l);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < 3; k++) begin
            d[32*k +: 32]     = l.p1[k];
            d[96 + 32*k +: 32] = l.p2[k];
        end
        d[192 +: 32] = l.m1;
        d[224 +: 32] = l.m2;
        d[256] = l.mov1;
        d[257] = l.mov2;
        d[258 +: 31] = l.rest;
        return d;
    endfunction

    function automatic t_link_in unpack_link(logic [IN_TDATA_W-1:0] d);
        t_link_in l;
        for (int k = 0; k < 3; k++) begin
            l.p1[k] = d[32*k +: 32];
            l.p2[k] = d[96 + 32*k +: 32];
        end
        l.m1 = d[192 +: 32];
        l.m2 = d[224 +: 32];
        l.mov1 = d[256];
        l.mov2 = d[257];
        l.rest = d[258 +: 31];
        return l;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    class link_tracker;
        int unsigned stiffness;
        t_link_out   expected_positions [$];
        int          errors;

        function new();
            stiffness = 65536;
            errors = 0;
        endfunction

        function t_link_out resolve_link(t_link_in l);
            t_link_out r;
            longint  p1 [3];
            longint  p2 [3];
            longint  d [3];
            logic [69:0] sumsq, root, cand;
            longint  len, q, w1, c, e, a, b;
            longint unsigned tot;
            sumsq = '0;
            for (int k = 0; k < 3; k++) begin
                p1[k] = l.p1[k];
                p2[k] = l.p2[k];
                d[k] = p1[k] - p2[k];
                sumsq += 70'(d[k] < 0 ? -d[k] : d[k]) * 70'(d[k] < 0 ? -d[k] : d[k]);
            end
            r.degen = (sumsq == 0);
            for (int k = 0; k < 3; k++) begin
                r.np[k] = l.p1[k];
                r.np[3+k] = l.p2[k];
            end
            if (sumsq != 0) begin
                root = '0;
                for (int bitn = 33; bitn >= 0; bitn--) begin
                    cand = root | (70'd1 << bitn);
                    if (cand * cand <= sumsq) root = cand;
                end
                len = longint'(root);
                q = ((len - longint'(l.rest)) * (64'sd1 <<< FRAC)) / len;
                tot = longint'(l.m1) + longint'(l.m2);
                w1 = (tot != 0) ? longint'((64'(l.m2) << FRAC) / tot) : (64'sd1 <<< (FRAC-1));
                for (int k = 0; k < 3; k++) begin
                    c = (d[k] * q) / (64'sd1 <<< FRAC);
                    e = (c * longint'(stiffness)) / 65536;
                    a = (e * w1) / (64'sd1 <<< FRAC);
                    b = e - a;
                    if (l.mov1 && l.mov2) begin
                        r.np[k] = clamp32(p1[k] - a);
                        r.np[3+k] = clamp32(p2[k] + b);
                    end else if (l.mov1) begin
                        r.np[k] = clamp32(p1[k] - e);
                    end else if (l.mov2) begin
                        r.np[3+k] = clamp32(p2[k] + e);
                    end
                end
            end
            return r;
        endfunction

        function void note_request(t_link_in l);
            expected_positions.push_back(resolve_link(l));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_link_out want;
            string  names [6] = '{"new_first_x", "new_first_y", "new_first_z",
                                  "new_second_x", "new_second_y", "new_second_z"};
            if (expected_positions.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            want = expected_positions.pop_front();
            for (int k = 0; k < 6; k++) begin
                if (d[32*k +: 32] !== want.np[k]) begin
                    $error("%s expected %0d actual %0d", names[k], want.np[k],
                           $signed(d[32*k +: 32]));
                    errors++;
                end
            end
            if (d[192] !== want.degen) begin
                $error("degenerate expected %0b actual %0b", want.degen, d[192]);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [STIFF_W-1:0]     i_cfg_wdata;

    link_tracker tracker = new();
    longint      cycles = 0;
    bit          long_hold_req = 0;
    int          stall_mode = 0;

    distance_constraint_resolver #(.COORD_FRAC_BITS(FRAC)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) tracker.note_request(unpack_link(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    end

    // receiver stall pattern
    initial begin
        m_axis_tready = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                long_hold_req = 0;
            end else begin
                case (stall_mode)
                    0: m_axis_tready <= 1;
                    1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                    default: m_axis_tready <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    task automatic send_link(t_link_in l);
        s_axis_tdata <= pack_link(l);
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (tracker.expected_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stiffness(int unsigned v);
        i_cfg_we <= 1;
        i_cfg_wdata <= v[STIFF_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        tracker.stiffness = v;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        logic [31:0] m;
        case ($urandom_range(0, 5))
            0: m = 1;
            1: m = 32'hffff_ffff;
            2: m = $urandom_range(1, 1 << 20);
            default: m = $urandom();
        endcase
        return (m == 0) ? 32'd1 : m;
    endfunction

    function automatic t_link_in random_link();
        t_link_in l;
        int    kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            if (kind <= 5) begin
                l.p1[k] = $urandom();
                l.p2[k] = l.p1[k] + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            end else if (kind <= 7) begin
                l.p1[k] = $urandom();
                l.p2[k] = $urandom();
            end else if (kind == 8) begin
                l.p1[k] = $urandom();
                l.p2[k] = l.p1[k];
            end else begin
                l.p1[k] = pick_coord();
                l.p2[k] = pick_coord();
            end
        end
        l.m1 = pick_mass();
        l.m2 = pick_mass();
        l.mov1 = $urandom_range(0, 3) != 0;
        l.mov2 = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 7))
            0: l.rest = 0;
            1: l.rest = 31'h7fff_ffff;
            2, 3: l.rest = 31'($urandom());
            default: l.rest = 31'($urandom_range(0, 1 << 21));
        endcase
        return l;
    endfunction

    function automatic t_link_in make_link(logic [31:0] a, logic [31:0] b, logic [31:0] m1,
                                           logic [31:0] m2, bit mv1, bit mv2,
                                           logic [30:0] rest);
        t_link_in l;
        for (int k = 0; k < 3; k++) begin
            l.p1[k] = a + k * 32'h0001_0000;
            l.p2[k] = b - k * 32'h0000_8000;
        end
        l.m1 = m1;
        l.m2 = m2;
        l.mov1 = mv1;
        l.mov2 = mv2;
        l.rest = rest;
        return l;
    endfunction

    task automatic run_random(int count, bit squeeze);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == count / 3) long_hold_req = 1;
            if (n % 60 == 0) stall_mode = $urandom_range(0, 2);
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if (stall_mode != 0 || $urandom_range(0, 1)) begin
                    s_axis_tvalid <= 0;
                    repeat ($urandom_range(1, 15)) @(posedge i_clk);
                end
            end
            burst--;
            send_link(random_link());
        end
    endtask

    initial begin
        t_link_in    l;
        int unsigned stiff_steps [6] = '{0, 65535, 1, 32768, 65536, 0};
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // coinciding points, then every movable combination on a separated link
        l = make_link(32'h0001_0000, 32'h0001_0000, 1, 1, 1, 1, 0);
        for (int k = 0; k < 3; k++) l.p2[k] = l.p1[k];
        send_link(l);
        l.mov1 = 0; l.mov2 = 0;
        send_link(l);
        for (int mv = 0; mv < 4; mv++) begin
            send_link(make_link(32'h0003_0000, 32'hfffd_0000, 32'h0001_0000, 32'h0003_0000,
                                mv[0], mv[1], 31'h0002_0000));
        end
        send_link(make_link(32'h7fff_ffff, 32'h8000_0000, 1, 32'hffff_ffff, 1, 1, 0));
        send_link(make_link(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1, 1, 1, 0));
        send_link(make_link(32'h7fff_ffff, 32'h8000_0000, 1, 1, 1, 0, 31'h7fff_ffff));
        send_link(make_link(32'h8000_0000, 32'h7fff_ffff, 1, 1, 0, 1, 31'h7fff_ffff));
        send_link(make_link(32'h0000_0010, 32'h0000_0000, 5, 7, 1, 1, 31'h7fff_ffff));
        send_link(make_link(32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff,
                            1, 1, 0));
        send_link(make_link(32'h0010_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
                            1, 1, 31'h0010_0000));
        for (int n = 0; n < 6; n++) begin
            l = random_link();
            for (int k = 0; k < 3; k++) begin
                l.p1[k] = pick_coord();
                l.p2[k] = pick_coord();
            end
            send_link(l);
        end
        wait_drained();

        run_random(220, 1);
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_stiffness(p == 5 ? $urandom_range(0, 65536) : stiff_steps[p]);
            @(posedge i_clk);
            run_random(180, p == 2);
        end

        wait_drained();
        if (tracker.expected_positions.size() != 0) tracker.errors++;
        if (tracker.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
